// ===== src/spq_pkg.sv =====
// package: types, codes and default sizes for the sorted priority queue
package spq_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned ITEM_BITS_DEF = 16;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned COUNT_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_EXTRACT = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_CHANGE  = 3'd3,
    CMD_PEEK    = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_EMPTY     = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_ABSENT    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PLACE  = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PLACE = 2'd1,
    ST_RESP  = 2'd2
  } state_e;

endpackage

// ===== src/sorted_priority_queue.sv =====
// top level: sorted priority queue built from a row of shifting cells
//
//   channel | valid      | ready      | payload
//   --------+------------+------------+------------------------------------------------
//   in      | in_valid_i | in_ready_o | cmd_i, item_value_i, priority_value_i
//   out     | out_valid_o| out_ready_i| status_o, head_item_o, head_priority_o, entry_count_o
//
// a command updates the whole cell row at once at the accepting edge; the result register
// is loaded from the response state once the output is free; change priority of a present
// item first closes the gap in the row and then, in the place state, places the pair again.
// one command at a time; while a result waits on out_ready_i one more command can
// run, and its result then holds off further commands.
// reset clears the entry count and handshake state only; no clearing pass.
module sorted_priority_queue #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_BITS = spq_pkg::ITEM_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [spq_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  item_value_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  priority_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [spq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [spq_pkg::VALUE_W-1:0]  head_item_o,
  output logic signed [spq_pkg::VALUE_W-1:0]  head_priority_o,
  output logic [spq_pkg::COUNT_W-1:0]         entry_count_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  spq_pkg::state_e   state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;

  spq_pkg::status_e  status_q, dec_status;
  logic              taken_q, dec_taken;
  logic [ITEM_BITS-1:0]               t_item_q;
  logic signed [spq_pkg::VALUE_W-1:0] t_prio_q;
  logic [ITEM_BITS-1:0]               pend_item_q;
  logic signed [spq_pkg::VALUE_W-1:0] pend_prio_q;

  spq_pkg::cell_op_e dec_op, cell_op;
  logic [CNT_W-1:0]  dec_count;
  logic              dec_two;
  logic              dec_rm_head;

  logic              accept, out_free, load_out;
  logic              empty, full, found;
  logic [31:0]       item_in_wide;
  logic [ITEM_BITS-1:0]               port_item;
  logic [ITEM_BITS-1:0]               key_item;
  logic signed [spq_pkg::VALUE_W-1:0] key_prio;
  logic              hit_head;

  logic [ITEM_BITS-1:0]               item_w [DEPTH];
  logic signed [spq_pkg::VALUE_W-1:0] prio_w [DEPTH];
  logic              ge_w  [DEPTH];
  logic              hit_w [DEPTH];

  logic              out_valid_q;
  spq_pkg::status_e  out_status_q;
  logic signed [spq_pkg::VALUE_W-1:0] out_item_q, out_prio_q;
  logic [spq_pkg::COUNT_W-1:0]        out_count_q;
  logic [31:0]       head_wide, count_wide;
  logic [ITEM_BITS-1:0]               res_item;
  logic signed [spq_pkg::VALUE_W-1:0] res_prio;

  assign in_ready_o = (state_q == spq_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign empty = (count_q == '0);
  assign full  = (count_q == CNT_W'(DEPTH));

  assign item_in_wide = {16'b0, item_value_i};
  assign port_item    = item_in_wide[ITEM_BITS-1:0];
  assign key_item     = (state_q == spq_pkg::ST_PLACE) ? pend_item_q : port_item;
  assign key_prio     = (state_q == spq_pkg::ST_PLACE) ? pend_prio_q : priority_value_i;
  assign dec_rm_head  = (spq_pkg::cmd_e'(cmd_i) == spq_pkg::CMD_EXTRACT) && !empty;
  assign hit_head     = accept && dec_rm_head;
  assign found        = hit_w[DEPTH-1];

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_BITS-1:0]               l_item, r_item;
    logic signed [spq_pkg::VALUE_W-1:0] l_prio, r_prio;
    logic                               l_ge, l_hit;
    if (i == 0) begin : g_first
      assign l_item = '0;
      assign l_prio = '0;
      assign l_ge   = 1'b1;
      assign l_hit  = hit_head;
    end else begin : g_mid
      assign l_item = item_w[i-1];
      assign l_prio = prio_w[i-1];
      assign l_ge   = ge_w[i-1];
      assign l_hit  = hit_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_item = '0;
      assign r_prio = '0;
    end else begin : g_inner
      assign r_item = item_w[i+1];
      assign r_prio = prio_w[i+1];
    end
    spq_cell #(
      .ITEM_BITS(ITEM_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .occ_i       (CNT_W'(i) < count_q),
      .key_item_i  (key_item),
      .key_prio_i  (key_prio),
      .left_item_i (l_item),
      .left_prio_i (l_prio),
      .left_ge_i   (l_ge),
      .right_item_i(r_item),
      .right_prio_i(r_prio),
      .hit_left_i  (l_hit),
      .item_o      (item_w[i]),
      .prio_o      (prio_w[i]),
      .ge_o        (ge_w[i]),
      .hit_o       (hit_w[i])
    );
  end

  // command decode
  always_comb begin
    dec_status  = spq_pkg::STATUS_OK;
    dec_op      = spq_pkg::CELL_HOLD;
    dec_count   = count_q;
    dec_taken   = 1'b0;
    dec_two     = 1'b0;
    case (spq_pkg::cmd_e'(cmd_i))
      spq_pkg::CMD_INSERT: begin
        if (full) begin
          dec_status = spq_pkg::STATUS_FULL;
        end else begin
          dec_op    = spq_pkg::CELL_PLACE;
          dec_count = count_q + 1'b1;
        end
      end
      spq_pkg::CMD_EXTRACT: begin
        dec_taken = 1'b1;
        if (empty) begin
          dec_status = spq_pkg::STATUS_EMPTY;
        end else begin
          dec_op      = spq_pkg::CELL_REMOVE;
          dec_count   = count_q - 1'b1;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (empty) begin
          dec_status = spq_pkg::STATUS_EMPTY;
        end else if (!found) begin
          dec_status = spq_pkg::STATUS_NOT_FOUND;
        end else begin
          dec_op    = spq_pkg::CELL_REMOVE;
          dec_count = count_q - 1'b1;
        end
      end
      spq_pkg::CMD_CHANGE: begin
        if (empty) begin
          dec_status = spq_pkg::STATUS_EMPTY;
        end else if (found) begin
          dec_op    = spq_pkg::CELL_REMOVE;
          dec_count = count_q - 1'b1;
          dec_two   = 1'b1;
        end else if (full) begin
          dec_status = spq_pkg::STATUS_FULL;
        end else begin
          dec_status = spq_pkg::STATUS_ABSENT;
          dec_op     = spq_pkg::CELL_PLACE;
          dec_count  = count_q + 1'b1;
        end
      end
      spq_pkg::CMD_PEEK: begin
        dec_taken = 1'b1;
        if (empty) begin
          dec_status = spq_pkg::STATUS_EMPTY;
        end
      end
      spq_pkg::CMD_CLEAR: begin
        dec_count = '0;
      end
      default: begin
        dec_status = spq_pkg::STATUS_OK;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = dec_two ? spq_pkg::ST_PLACE : spq_pkg::ST_RESP;
        end
      end
      spq_pkg::ST_PLACE: begin
        state_d = spq_pkg::ST_RESP;
      end
      spq_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    cell_op  = spq_pkg::CELL_HOLD;
    count_d  = count_q;
    load_out = 1'b0;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          cell_op = dec_op;
          count_d = dec_count;
        end
      end
      spq_pkg::ST_PLACE: begin
        cell_op = spq_pkg::CELL_PLACE;
        count_d = count_q + 1'b1;
      end
      spq_pkg::ST_RESP: begin
        load_out = out_free;
      end
      default: begin
        cell_op = spq_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= dec_status;
      taken_q     <= dec_taken;
      t_item_q    <= empty ? '0 : item_w[0];
      t_prio_q    <= empty ? '0 : prio_w[0];
      pend_item_q <= port_item;
      pend_prio_q <= priority_value_i;
    end
  end

  // result register
  always_comb begin
    if (taken_q) begin
      res_item = t_item_q;
      res_prio = t_prio_q;
    end else if (count_q != '0) begin
      res_item = item_w[0];
      res_prio = prio_w[0];
    end else begin
      res_item = '0;
      res_prio = '0;
    end
  end

  assign head_wide  = 32'(res_item);
  assign count_wide = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_item_q   <= head_wide[spq_pkg::VALUE_W-1:0];
      out_prio_q   <= res_prio;
      out_count_q  <= count_wide[spq_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign head_item_o     = out_item_q;
  assign head_priority_o = out_prio_q;
  assign entry_count_o   = out_count_q;

endmodule

// ===== src/spq_cell.sv =====
// one queue slot: holds an item and its priority, shifts with its neighbors
module spq_cell #(
  parameter int unsigned ITEM_BITS = spq_pkg::ITEM_BITS_DEF
) (
  input  logic                                clk_i,
  input  spq_pkg::cell_op_e                   op_i,
  input  logic                                occ_i,
  input  logic [ITEM_BITS-1:0]                key_item_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  key_prio_i,
  input  logic [ITEM_BITS-1:0]                left_item_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  left_prio_i,
  input  logic                                left_ge_i,
  input  logic [ITEM_BITS-1:0]                right_item_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  right_prio_i,
  input  logic                                hit_left_i,
  output logic [ITEM_BITS-1:0]                item_o,
  output logic signed [spq_pkg::VALUE_W-1:0]  prio_o,
  output logic                                ge_o,
  output logic                                hit_o
);

  logic [ITEM_BITS-1:0]               item_q, item_d;
  logic signed [spq_pkg::VALUE_W-1:0] prio_q, prio_d;

  assign item_o = item_q;
  assign prio_o = prio_q;
  assign ge_o   = occ_i && (prio_q >= key_prio_i);
  assign hit_o  = hit_left_i || (occ_i && (item_q == key_item_i));

  always_comb begin
    item_d = item_q;
    prio_d = prio_q;
    case (op_i)
      spq_pkg::CELL_PLACE: begin
        if (!ge_o) begin
          if (left_ge_i) begin
            item_d = key_item_i;
            prio_d = key_prio_i;
          end else begin
            item_d = left_item_i;
            prio_d = left_prio_i;
          end
        end
      end
      spq_pkg::CELL_REMOVE: begin
        if (hit_o) begin
          item_d = right_item_i;
          prio_d = right_prio_i;
        end
      end
      default: begin
        item_d = item_q;
        prio_d = prio_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prio_q <= prio_d;
  end

endmodule

// ===== src/spq_checker.sv =====
// port checker for the sorted priority queue, bound to the top level
module spq_checker #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [spq_pkg::STATUS_W-1:0]        status_o,
  input logic signed [spq_pkg::VALUE_W-1:0]  head_item_o,
  input logic signed [spq_pkg::VALUE_W-1:0]  head_priority_o,
  input logic [spq_pkg::COUNT_W-1:0]         entry_count_o
);

  localparam logic [31:0] DEPTH_WIDE = 32'(DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(head_item_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= spq_pkg::STATUS_ABSENT)
    else $error("undefined status code");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::STATUS_EMPTY |->
      entry_count_o == '0 && head_item_o == '0 && head_priority_o == '0)
    else $error("empty status with entries or a head");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::STATUS_FULL |->
      entry_count_o == DEPTH_WIDE[spq_pkg::COUNT_W-1:0])
    else $error("full status with queue not full");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH(DEPTH)
) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .head_item_o    (head_item_o),
  .head_priority_o(head_priority_o),
  .entry_count_o  (entry_count_o)
);
